// ===== rtl/core/segregated_free_list_manager_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SEGREGATED_FREE_LIST_MANAGER_ASSERT_SVH
`define SEGREGATED_FREE_LIST_MANAGER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFL_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/sfl_pkg.sv =====
package sfl_pkg;

  localparam int SFL_NODES     = 256;
  localparam int SFL_CLASSES   = 32;
  localparam int NODE_FIELD_W  = 8;
  localparam int CLASS_FIELD_W = 5;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic                     op;
    logic [NODE_FIELD_W-1:0]  node;
    logic [CLASS_FIELD_W-1:0] size_class;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       class_empty_after;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD,
    S_LINK,
    S_HEAD_CHK,
    S_WALK,
    S_UNLINK,
    S_DETACH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       rd_head;
    logic       rd_walk;
    logic       rd_node;
    logic       add_node;
    logic       add_link;
    logic       head_remove;
    logic       unlink;
    logic       detach;
    logic       set_st;
    logic [1:0] st_code;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_add;
    logic cls_ok;
    logic node_ok;
    logic nonempty;
    logic head_hit;
    logic rd_end;
    logic nxt_hit;
    logic steps_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/core/segregated_free_list_manager.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_item_t: op, node, size_class
// out     | output    | out_valid/out_stall| out_item_t: status, class_empty_after
//
// One transaction at a time. An append writes the node's entry and, when the class already
// holds nodes, links it behind the tail. A remove of the head moves the head pointer; a remove
// past the head walks the list, up to NODES steps, with one registered link-store read per step,
// then unlinks and detaches the node. Early rejections (class, empty class, node) go to finish.
// rst_n (synchronous) clears the controller, the non-empty flags and the output valid flag.
// A transaction is taken while a result waits under out_stall; its result holds until free.
module segregated_free_list_manager import sfl_pkg::*; #(
  parameter int NODES   = SFL_NODES,
  parameter int CLASSES = SFL_CLASSES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfl_datapath #(
    .NODES   (NODES),
    .CLASSES (CLASSES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/core/sfl_ctrl.sv =====
module sfl_ctrl import sfl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (!sts.cls_ok) begin
          state_nxt = S_FINISH;
        end else if (sts.is_add) begin
          state_nxt = sts.node_ok ? S_ADD : S_FINISH;
        end else if (!sts.nonempty || !sts.node_ok) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_HEAD_CHK;
        end
      end
      S_ADD: begin
        state_nxt = sts.nonempty ? S_LINK : S_FINISH;
      end
      S_LINK: begin
        state_nxt = S_FINISH;
      end
      S_HEAD_CHK: begin
        state_nxt = sts.head_hit ? S_FINISH : S_WALK;
      end
      S_WALK: begin
        if (sts.steps_done || sts.rd_end) begin
          state_nxt = S_FINISH;
        end else if (sts.nxt_hit) begin
          state_nxt = S_UNLINK;
        end
      end
      S_UNLINK: begin
        state_nxt = S_DETACH;
      end
      S_DETACH: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
      end
      S_DECODE: begin
        if (!sts.cls_ok) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_EMPTY;
        end else if (sts.is_add) begin
          if (!sts.node_ok) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_NOT_FOUND;
          end
        end else if (!sts.nonempty) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_EMPTY;
        end else if (!sts.node_ok) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_NOT_FOUND;
        end else begin
          cmd.rd_head = 1'b1;
        end
      end
      S_ADD: begin
        cmd.add_node = 1'b1;
        cmd.set_st   = 1'b1;
        cmd.st_code  = ST_DONE;
      end
      S_LINK: begin
        cmd.add_link = 1'b1;
      end
      S_HEAD_CHK: begin
        if (sts.head_hit) begin
          cmd.head_remove = 1'b1;
          cmd.set_st      = 1'b1;
          cmd.st_code     = ST_DONE;
        end
      end
      S_WALK: begin
        if (sts.steps_done || sts.rd_end) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_NOT_FOUND;
        end else if (sts.nxt_hit) begin
          cmd.rd_node = 1'b1;
        end else begin
          cmd.rd_walk = 1'b1;
        end
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
      end
      S_DETACH: begin
        cmd.detach  = 1'b1;
        cmd.set_st  = 1'b1;
        cmd.st_code = ST_DONE;
      end
      S_FINISH: begin
        cmd.out_load = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/sfl_datapath.sv =====
module sfl_datapath import sfl_pkg::*; #(
  parameter int NODES   = SFL_NODES,
  parameter int CLASSES = SFL_CLASSES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts
);

  localparam int NODE_W = $clog2(NODES);
  localparam int CLS_W  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int STEP_W = $clog2(NODES + 1);

  // latched transaction
  logic                     op_r;
  logic [NODE_FIELD_W-1:0]  node_r;
  logic [CLASS_FIELD_W-1:0] cls_r;

  logic [NODE_W-1:0] node_idx;
  logic [CLS_W-1:0]  cls_idx;
  logic              cls_ok;
  logic              node_ok;
  logic              nonempty_cur;

  // per-class pointers and flags
  logic [NODE_W-1:0]  head_r [CLASSES];
  logic [NODE_W-1:0]  tail_r [CLASSES];
  logic [CLASSES-1:0] nonempty_r, nonempty_nxt;

  // shared link store: end bit above next pointer
  logic [NODE_W:0]   mem [NODES];
  logic [NODE_W:0]   rd_data_r;
  logic              rd_end;
  logic [NODE_W-1:0] rd_next;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [NODE_W:0]   wr_data;

  logic [NODE_W-1:0] prev_r, prev_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [1:0]        st_r, st_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;
  logic              out_free;

  assign node_idx     = NODE_W'(node_r);
  assign cls_idx      = CLS_W'(cls_r);
  assign cls_ok       = 32'(cls_r) < CLASSES;
  assign node_ok      = 32'(node_r) < NODES;
  assign nonempty_cur = cls_ok && nonempty_r[cls_idx];
  assign rd_end       = rd_data_r[NODE_W];
  assign rd_next      = rd_data_r[NODE_W-1:0];
  assign out_free     = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_data.op;
      node_r <= in_data.node;
      cls_r  <= in_data.size_class;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.rd_head) begin
      rd_en   = 1'b1;
      rd_addr = head_r[cls_idx];
    end else if (cmd.rd_walk) begin
      rd_en   = 1'b1;
      rd_addr = rd_next;
    end else if (cmd.rd_node) begin
      rd_en   = 1'b1;
      rd_addr = node_idx;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd.add_node) begin
      wr_en   = 1'b1;
      wr_addr = node_idx;
      wr_data = {1'b1, {NODE_W{1'b0}}};
    end else if (cmd.add_link) begin
      wr_en   = 1'b1;
      wr_addr = tail_r[cls_idx];
      wr_data = {1'b0, node_idx};
    end else if (cmd.head_remove || cmd.detach) begin
      // read data still holds this node's entry: keep its pointer, mark end
      wr_en   = 1'b1;
      wr_addr = node_idx;
      wr_data = {1'b1, rd_next};
    end else if (cmd.unlink) begin
      wr_en   = 1'b1;
      wr_addr = prev_r;
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.add_node && !nonempty_cur) begin
      head_r[cls_idx] <= node_idx;
      tail_r[cls_idx] <= node_idx;
    end
    if (cmd.add_link) tail_r[cls_idx] <= node_idx;
    if (cmd.head_remove && !rd_end) head_r[cls_idx] <= rd_next;
    if (cmd.unlink && (tail_r[cls_idx] == node_idx)) tail_r[cls_idx] <= prev_r;
  end

  always_comb begin
    nonempty_nxt = nonempty_r;
    if (cmd.add_node) nonempty_nxt[cls_idx] = 1'b1;
    if (cmd.head_remove && rd_end) nonempty_nxt[cls_idx] = 1'b0;
  end

  always_comb begin
    prev_nxt  = prev_r;
    steps_nxt = steps_r;
    if (cmd.rd_head) begin
      prev_nxt  = head_r[cls_idx];
      steps_nxt = '0;
    end else if (cmd.rd_walk) begin
      prev_nxt  = rd_next;
      steps_nxt = steps_r + 1'b1;
    end
  end

  assign st_nxt = cmd.set_st ? cmd.st_code : st_r;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r  <= prev_nxt;
    steps_r <= steps_nxt;
    st_r    <= st_nxt;
    if (cmd.out_load) begin
      out_data_r.status            <= st_r;
      out_data_r.class_empty_after <= !nonempty_cur;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.is_add     = (op_r == OP_ADD);
  assign sts.cls_ok     = cls_ok;
  assign sts.node_ok    = node_ok;
  assign sts.nonempty   = nonempty_cur;
  assign sts.head_hit   = (head_r[cls_idx] == node_idx);
  assign sts.rd_end     = rd_end;
  assign sts.nxt_hit    = (rd_next == node_idx);
  assign sts.steps_done = (steps_r == STEP_W'(NODES));
  assign sts.out_free   = out_free;

endmodule

// ===== rtl/core/sfl_checker.sv =====
`include "segregated_free_list_manager_assert.svh"

module sfl_checker import sfl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // hold a stalled result
  `SFL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one transaction in flight: busy right after acceptance
  `SFL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a fresh result is only produced while a transaction is in flight
  `SFL_ASSERT_IMPLY(a_result_from_work, $rose(out_valid), $past(in_stall))

  // an empty-class result always reports the class empty
  `SFL_ASSERT_IMPLY(a_empty_flag, out_valid && (out_data.status == ST_EMPTY), out_data.class_empty_after)

endmodule

bind segregated_free_list_manager sfl_checker u_sfl_checker (.*);

// ===== sim/tb_segregated_free_list_manager.sv =====
module tb_segregated_free_list_manager;
  import sfl_pkg::*;

  typedef struct packed {
    logic      known;
    in_item_t  item;
    out_item_t res;
  } dir_row_t;

  localparam int DIR_LEN = 24;
  localparam int SEGMENTS = 8;
  localparam int SEG_ITEMS = 244;

  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    '{1'b1, '{OP_REMOVE, 8'd0,   5'd0},  '{ST_EMPTY,     1'b1}},
    '{1'b1, '{OP_REMOVE, 8'd255, 5'd31}, '{ST_EMPTY,     1'b1}},
    '{1'b1, '{OP_ADD,    8'd0,   5'd0},  '{ST_DONE,      1'b0}},
    '{1'b1, '{OP_ADD,    8'd255, 5'd31}, '{ST_DONE,      1'b0}},
    '{1'b1, '{OP_REMOVE, 8'd1,   5'd0},  '{ST_NOT_FOUND, 1'b0}},
    '{1'b1, '{OP_REMOVE, 8'd0,   5'd0},  '{ST_DONE,      1'b1}},
    '{1'b1, '{OP_REMOVE, 8'd0,   5'd0},  '{ST_EMPTY,     1'b1}},
    '{1'b0, '{OP_ADD,    8'd10,  5'd3},  '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_ADD,    8'd11,  5'd3},  '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_ADD,    8'd12,  5'd3},  '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_ADD,    8'd13,  5'd3},  '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_REMOVE, 8'd12,  5'd3},  '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_REMOVE, 8'd13,  5'd3},  '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_ADD,    8'd14,  5'd3},  '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_REMOVE, 8'd99,  5'd3},  '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_REMOVE, 8'd10,  5'd3},  '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_REMOVE, 8'd14,  5'd3},  '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_REMOVE, 8'd11,  5'd3},  '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_ADD,    8'd7,   5'd30}, '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_ADD,    8'd7,   5'd30}, '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_REMOVE, 8'd9,   5'd30}, '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_REMOVE, 8'd7,   5'd30}, '{ST_DONE,      1'b0}},
    '{1'b0, '{OP_ADD,    8'd8,   5'd30}, '{ST_DONE,      1'b0}},
    '{1'b1, '{OP_REMOVE, 8'd255, 5'd31}, '{ST_DONE,      1'b1}}
  };

  // idle and stall percentages cycle through four modes
  localparam int SEG_IDLE  [4] = '{0, 50, 0, 10};
  localparam int SEG_STALL [4] = '{0, 0, 50, 10};
  localparam int SEG_ADD   [SEGMENTS] = '{65, 55, 50, 45, 80, 50, 35, 50};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // mirror of the list state
  bit [NODE_FIELD_W-1:0] fl_head [SFL_CLASSES];
  bit [NODE_FIELD_W-1:0] fl_tail [SFL_CLASSES];
  bit                    cls_busy [SFL_CLASSES];
  bit [NODE_FIELD_W-1:0] link_nxt [SFL_NODES];
  bit                    link_end [SFL_NODES];

  int        home_cls [SFL_NODES];
  out_item_t results_due [$];
  out_item_t want;
  int        fail_count = 0;
  int        stall_pct = 0;

  segregated_free_list_manager i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic out_item_t free_list_op(in_item_t it);
    out_item_t             res;
    bit [CLASS_FIELD_W-1:0] c;
    bit [NODE_FIELD_W-1:0]  nd;
    bit [NODE_FIELD_W-1:0]  prev;
    bit [NODE_FIELD_W-1:0]  nxt;
    logic [1:0]             st;
    c = it.size_class;
    nd = it.node;
    if (it.op == OP_ADD) begin
      link_end[nd] = 1'b1;
      link_nxt[nd] = '0;
      if (!cls_busy[c]) begin
        fl_head[c] = nd;
        fl_tail[c] = nd;
        cls_busy[c] = 1'b1;
      end else begin
        link_nxt[fl_tail[c]] = nd;
        link_end[fl_tail[c]] = 1'b0;
        fl_tail[c] = nd;
      end
      res.status = ST_DONE;
      res.class_empty_after = 1'b0;
      return res;
    end
    if (!cls_busy[c]) begin
      res.status = ST_EMPTY;
      res.class_empty_after = 1'b1;
      return res;
    end
    prev = fl_head[c];
    if (prev == nd) begin
      if (link_end[nd]) cls_busy[c] = 1'b0;
      else fl_head[c] = link_nxt[nd];
      link_end[nd] = 1'b1;
      st = ST_DONE;
    end else begin
      st = ST_NOT_FOUND;
      // bound the walk so that a looped list still ends
      for (int k = 0; k < SFL_NODES; k++) begin
        if (link_end[prev]) break;
        nxt = link_nxt[prev];
        if (nxt == nd) begin
          link_nxt[prev] = link_nxt[nd];
          link_end[prev] = link_end[nd];
          if (fl_tail[c] == nd) fl_tail[c] = prev;
          link_end[nd] = 1'b1;
          st = ST_DONE;
          break;
        end
        prev = nxt;
      end
    end
    res.status = st;
    res.class_empty_after = !cls_busy[c];
    return res;
  endfunction

  // work out which class each node can be reached from
  function automatic void map_members();
    bit [NODE_FIELD_W-1:0] p;
    foreach (home_cls[i]) home_cls[i] = -1;
    for (int c = 0; c < SFL_CLASSES; c++) begin
      if (cls_busy[c]) begin
        p = fl_head[c];
        for (int k = 0; k < SFL_NODES; k++) begin
          if (home_cls[p] < 0) home_cls[p] = c;
          if (link_end[p]) break;
          p = link_nxt[p];
        end
      end
    end
  endfunction

  function automatic int find_node(bit listed);
    int start;
    int idx;
    start = $urandom_range(0, SFL_NODES - 1);
    for (int k = 0; k < SFL_NODES; k++) begin
      idx = (start + k) % SFL_NODES;
      if ((home_cls[idx] >= 0) == listed) return idx;
    end
    return -1;
  endfunction

  function automatic in_item_t pick_item(int add_pct, int cls_hi, bit dup_ok);
    in_item_t it;
    int       r;
    int       n;
    map_members();
    r = $urandom_range(0, 99);
    it.op = OP_REMOVE;
    it.node = NODE_FIELD_W'($urandom_range(0, SFL_NODES - 1));
    it.size_class = CLASS_FIELD_W'($urandom_range(0, SFL_CLASSES - 1));
    if (r < 6) return it;
    if (dup_ok && r < 8) begin
      // re-add a node that is already listed
      n = find_node(1'b1);
      it.op = OP_ADD;
      if (n >= 0) it.node = NODE_FIELD_W'(n);
      return it;
    end
    if (cls_hi > 1 && $urandom_range(0, 99) < 30) begin
      it.size_class = CLASS_FIELD_W'($urandom_range(0, 1));
    end else begin
      it.size_class = CLASS_FIELD_W'($urandom_range(0, cls_hi));
    end
    n = -1;
    if ($urandom_range(0, 99) < add_pct) begin
      n = find_node(1'b0);
      if (n >= 0) begin
        it.op = OP_ADD;
        it.node = NODE_FIELD_W'(n);
        return it;
      end
    end
    n = find_node(1'b1);
    if (n >= 0) begin
      it.node = NODE_FIELD_W'(n);
      it.size_class = CLASS_FIELD_W'(home_cls[n]);
    end
    return it;
  endfunction

  // call at a rising edge; returns at the edge where the transaction is taken
  task automatic submit(in_item_t it, bit known, out_item_t known_res);
    out_item_t res;
    bit        taken;
    in_data <= it;
    in_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    res = free_list_op(it);
    results_due.push_back(known ? known_res : res);
  endtask

  task automatic pace(int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // compare mid-cycle, where the transaction about to complete is stable
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none due: status %0d empty_after %0d",
                 $time, out_data.status, out_data.class_empty_after);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_data.status);
          fail_count++;
        end
        if (out_data.class_empty_after !== want.class_empty_after) begin
          $display("%0t: class_empty_after expected %0d got %0d",
                   $time, want.class_empty_after, out_data.class_empty_after);
          fail_count++;
        end
      end
    end
  end

  initial begin
    in_item_t it;
    out_item_t none;
    none = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_LEN; r++) begin
      submit(DIR_ROWS[r].item, DIR_ROWS[r].known, DIR_ROWS[r].res);
    end
    hold_until_drained();

    for (int s = 0; s < SEGMENTS; s++) begin
      stall_pct = SEG_STALL[s % 4];
      for (int i = 0; i < SEG_ITEMS; i++) begin
        pace(SEG_IDLE[s % 4]);
        // one segment crowds class 0 to force long walks
        it = pick_item(SEG_ADD[s], (s == 4) ? 0 : SFL_CLASSES - 1, s == SEGMENTS - 1);
        submit(it, 1'b0, none);
      end
      hold_until_drained();
    end

    stall_pct = 0;
    repeat (SFL_NODES + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #48_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
